FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/rch_pkg.sv
// Shared types, constants and the bin mapping of the color cube histogram.
// No dependencies; used by every module of the block.
package rch_pkg;

  localparam int CHANNEL_BITS = 4;
  localparam int COUNT_WIDTH  = 32;
  localparam int RED_BITS     = CHANNEL_BITS;
  localparam int GREEN_BITS   = CHANNEL_BITS;
  localparam int BLUE_BITS    = CHANNEL_BITS;
  localparam int BIN_BITS     = RED_BITS + GREEN_BITS + BLUE_BITS;
  localparam int BIN_COUNT    = 1 << BIN_BITS;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
    logic [BIN_BITS-1:0] bin_index;
    logic                row_end;
  } pixel_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]    bin;
    logic [COUNT_WIDTH-1:0] count;
    logic                   row_end_out;
  } result_t;

  // classified item as queued between front and back
  typedef struct packed {
    logic                op;
    logic [BIN_BITS-1:0] bin;
    logic                row_end;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // red in the high bits, blue in the low bits
  function automatic logic [BIN_BITS-1:0] cube_bin(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
    cube_bin = {r[7 -: RED_BITS], g[7 -: GREEN_BITS], b[7 -: BLUE_BITS]};
  endfunction

endpackage

FILE: hdl/rch_front.sv
// Front end: accepts pixel items, forms the bin number and registers the entry.
// Depends on rch_pkg.
module rch_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            hold,
  input  logic            pixel_valid,
  output logic            pixel_ready,
  input  rch_pkg::pixel_t pixel,
  output logic            ent_valid,
  input  logic            ent_ready,
  output rch_pkg::entry_t ent
);

  rch_pkg::entry_t ent_next;

  always_comb begin
    ent_next.op      = pixel.command;
    ent_next.row_end = pixel.row_end;
    if (pixel.command == rch_pkg::CMD_READ) begin
      ent_next.bin = pixel.bin_index;
    end else begin
      ent_next.bin = rch_pkg::cube_bin(pixel.red, pixel.green, pixel.blue);
    end
  end

  assign pixel_ready = !hold && (!ent_valid || ent_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (pixel_ready) begin
      ent_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      ent <= ent_next;
    end
  end

endmodule

FILE: hdl/rch_queue.sv
// Short queue of classified entries between front and back end.
// Depends on rch_pkg.
module rch_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  rch_pkg::entry_t push_ent,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rch_pkg::entry_t pop_ent,
  output rch_pkg::qstat_t stat
);

  localparam logic [rch_pkg::QPTR_BITS:0] FULL_FILL = (rch_pkg::QPTR_BITS + 1)'(rch_pkg::QUEUE_DEPTH);

  rch_pkg::entry_t                 slots [rch_pkg::QUEUE_DEPTH];
  logic [rch_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [rch_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [rch_pkg::QPTR_BITS:0]     fill;
  logic [rch_pkg::QPTR_BITS:0]     fill_next;
  logic                            push;
  logic                            pop;

  assign push_ready = (fill != FULL_FILL);
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_ent    = slots[rd_ptr];
  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FULL_FILL);

  always_comb begin
    case ({push, pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  // depth is a power of two, so the pointers wrap by themselves
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

endmodule

FILE: hdl/rch_back.sv
// Back end: counter memory, read-modify-write with forwarding, output register.
// Also runs the clearing pass after reset. Depends on rch_pkg.
module rch_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             ent_valid,
  output logic             ent_ready,
  input  rch_pkg::entry_t  ent,
  output logic             result_valid,
  input  logic             result_ready,
  output rch_pkg::result_t result,
  output logic             clearing
);

  localparam logic [rch_pkg::BIN_BITS-1:0] LAST_BIN = rch_pkg::BIN_BITS'(rch_pkg::BIN_COUNT - 1);

  logic [rch_pkg::COUNT_WIDTH-1:0] mem [rch_pkg::BIN_COUNT];

  logic [rch_pkg::BIN_BITS-1:0]    clr_addr;
  logic                            advance;
  logic                            pop;
  logic                            b_valid;
  rch_pkg::entry_t                 b_ent;
  logic [rch_pkg::COUNT_WIDTH-1:0] rd_q;
  logic                            wb_valid;
  logic [rch_pkg::BIN_BITS-1:0]    wb_bin;
  logic [rch_pkg::COUNT_WIDTH-1:0] wb_cnt;
  logic [rch_pkg::COUNT_WIDTH-1:0] operand;
  logic [rch_pkg::COUNT_WIDTH-1:0] incr;
  logic [rch_pkg::COUNT_WIDTH-1:0] b_cnt;
  logic                            b_write;

  assign advance   = !result_valid || result_ready;
  assign ent_ready = advance && !clearing;
  assign pop       = ent_valid && ent_ready;

  // the write issued at the edge that read rd_q is not in rd_q yet
  assign operand = (wb_valid && (wb_bin == b_ent.bin)) ? wb_cnt : rd_q;
  assign incr    = operand + rch_pkg::COUNT_WIDTH'(1);
  assign b_cnt   = (b_ent.op == rch_pkg::CMD_READ) ? operand : incr;
  assign b_write = advance && b_valid && (b_ent.op == rch_pkg::CMD_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_BIN) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (b_write) begin
      mem[b_ent.bin] <= incr;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_q  <= mem[ent.bin];
      b_ent <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      wb_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      b_valid      <= pop;
      wb_valid     <= b_write;
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wb_bin <= b_ent.bin;
      wb_cnt <= incr;
    end
    if (advance && b_valid) begin
      result.bin         <= b_ent.bin;
      result.count       <= b_cnt;
      result.row_end_out <= b_ent.row_end;
    end
  end

endmodule

FILE: hdl/rgb_cube_histogram_top.sv
// Color cube histogram: one pixel or bin read per item, one result per item.
// Path: front entry register, queue, back read stage, then the output register.
// Throughput: one item per cycle while the output is not stalled and no clearing pass runs;
// the counter memory is read at one address and written at another, with the previous
// write forwarded for repeated bins. Reset: synchronous; afterwards a clearing pass
// zeroes the counters, one per cycle, and pixel_ready stays low until it ends.
`include "assert_macros.svh"

module rgb_cube_histogram_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  rch_pkg::pixel_t  pixel,
  output logic             result_valid,
  input  logic             result_ready,
  output rch_pkg::result_t result
);

  logic            clearing;
  logic            f_valid;
  logic            f_ready;
  rch_pkg::entry_t f_ent;
  logic            q_valid;
  logic            q_ready;
  rch_pkg::entry_t q_ent;
  rch_pkg::qstat_t q_stat;

  rch_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (clearing),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .ent_valid   (f_valid),
    .ent_ready   (f_ready),
    .ent         (f_ent)
  );

  rch_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_ent   (f_ent),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_ent    (q_ent),
    .stat       (q_stat)
  );

  rch_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ent_valid    (q_valid),
    .ent_ready    (q_ready),
    .ent          (q_ent),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .clearing     (clearing)
  );

  `ASSERT_IMPLY(a_no_accept_in_clear, pixel_valid && pixel_ready, !clearing, "accept in clear")
  `ASSERT_IMPLY(a_no_result_in_clear, clearing, !result_valid, "result during clearing pass")
  `ASSERT_ALWAYS(a_queue_stat, !(q_stat.full && q_stat.empty), "queue both full and empty")

endmodule

FILE: tb/tb_rgb_cube_histogram_top.sv
`timescale 1ns / 100ps
// Testbench for rgb_cube_histogram_top: counts pixels into color cube bins and
// reads bins back, predicting every result. Needs rch_pkg and the block's RTL.
module tb_rgb_cube_histogram_top;

  localparam int STALL_LIMIT = 20000;  // covers the clearing pass and long holds
  localparam int DRAIN_CYCLES = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pixel_valid = 1'b0;
  logic             pixel_ready;
  rch_pkg::pixel_t  pixel = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  rch_pkg::result_t result;

  logic [rch_pkg::COUNT_WIDTH-1:0] bin_tally [rch_pkg::BIN_COUNT];
  rch_pkg::result_t                pending_results [$];
  int                              mismatch_count = 0;
  int                              tx_idle_pct = 0;
  int                              rx_idle_pct = 0;
  int                              rx_hold_cycles = 0;
  logic [23:0]                     hot_rgb [4];

  rgb_cube_histogram_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(11, 40);
  endfunction

  // Updates the histogram copy and returns the result the item should produce
  function automatic rch_pkg::result_t tally_pixel(rch_pkg::pixel_t p);
    rch_pkg::result_t             res;
    logic [rch_pkg::BIN_BITS-1:0] idx;
    if (p.command == rch_pkg::CMD_COUNT) begin
      idx = {p.red[7 -: rch_pkg::RED_BITS], p.green[7 -: rch_pkg::GREEN_BITS],
             p.blue[7 -: rch_pkg::BLUE_BITS]};
      bin_tally[idx] = bin_tally[idx] + 1'b1;
    end else begin
      idx = p.bin_index;
    end
    res.bin         = idx;
    res.count       = bin_tally[idx];
    res.row_end_out = p.row_end;
    return res;
  endfunction

  function automatic rch_pkg::pixel_t make_item(logic cmd, logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b,
                                                logic [rch_pkg::BIN_BITS-1:0] idx,
                                                logic last);
    rch_pkg::pixel_t p;
    p.command   = cmd;
    p.red       = r;
    p.green     = g;
    p.blue      = b;
    p.bin_index = idx;
    p.row_end   = last;
    return p;
  endfunction

  // Called at a rising edge; returns at the rising edge of acceptance or after a gap
  task automatic send_pixel(rch_pkg::pixel_t p);
    pixel       <= p;
    pixel_valid <= 1'b1;
    do begin
      @(negedge clk);
    end while (!pixel_ready);
    @(posedge clk);
    pending_results.push_back(tally_pixel(p));
    if ($urandom_range(99) < tx_idle_pct) begin
      pixel_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic rch_pkg::pixel_t random_pixel(int hot_pct, int read_pct);
    rch_pkg::pixel_t p;
    logic [23:0]     rgb;
    p = make_item((($urandom_range(99) < read_pct) ? rch_pkg::CMD_READ : rch_pkg::CMD_COUNT),
                  8'($urandom), 8'($urandom), 8'($urandom),
                  rch_pkg::BIN_BITS'($urandom_range(0, rch_pkg::BIN_COUNT - 1)),
                  1'($urandom_range(0, 1)));
    if ($urandom_range(99) < hot_pct) begin
      // keep the bin of a hot color, vary only the dropped low bits
      rgb = hot_rgb[$urandom_range(0, 3)];
      p.red[7 -: rch_pkg::RED_BITS]     = rgb[23 -: rch_pkg::RED_BITS];
      p.green[7 -: rch_pkg::GREEN_BITS] = rgb[15 -: rch_pkg::GREEN_BITS];
      p.blue[7 -: rch_pkg::BLUE_BITS]   = rgb[7 -: rch_pkg::BLUE_BITS];
      p.bin_index = {rgb[23 -: rch_pkg::RED_BITS], rgb[15 -: rch_pkg::GREEN_BITS],
                     rgb[7 -: rch_pkg::BLUE_BITS]};
    end
    return p;
  endfunction

  task automatic test_directed_extremes();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h00, 8'h00, 8'h00, '1, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h0F, 8'h0F, 8'h0F, '0, 1'b1));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'hFF, 8'hFF, 8'hFF, '0, 1'b1));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, '1, 1'b1));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'hFF, 8'h00, 8'h00, 12'h0AA, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h00, 8'hFF, 8'h00, 12'h555, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h00, 8'h00, 8'hFF, 12'hFFF, 1'b1));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'h12, 8'h34, 8'h56, 12'hF00, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'hAB, 8'hCD, 8'hEF, 12'h0F0, 1'b1));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'h5A, 8'hA5, 8'h3C, 12'h00F, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 12'h123, 1'b0));
    // same bin back to back, then at distance two and three
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'hA5, 8'h5A, 8'hC3, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'hA0, 8'h50, 8'hC0, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 12'hA5C, 1'b1));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h80, 8'h40, 8'h10, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'hAF, 8'h5F, 8'hCF, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h8F, 8'h4F, 8'h1F, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h7F, 8'hBF, 8'hEF, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'h01, 8'h02, 8'h04, '0, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_COUNT, 8'hA1, 8'h52, 8'hC4, '0, 1'b1));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF, 12'h841, 1'b0));
    send_pixel(make_item(rch_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 12'hA5C, 1'b1));
  endtask

  task automatic test_random_stream(int n, int tx_pct, int rx_pct, int hot_pct,
                                    int read_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    foreach (hot_rgb[i]) hot_rgb[i] = 24'($urandom);
    repeat (n) send_pixel(random_pixel(hot_pct, read_pct));
  endtask

  // Receiver stalls for a long time while items keep coming, filling the block
  task automatic test_output_backpressure();
    wait_drained();
    tx_idle_pct    = 0;
    rx_idle_pct    = 10;
    rx_hold_cycles = 300;
    foreach (hot_rgb[i]) hot_rgb[i] = 24'($urandom);
    repeat (60) send_pixel(random_pixel(70, 20));
  endtask

  // Results must be right when the pipeline restarts from empty
  task automatic test_pause_until_drained();
    tx_idle_pct = 10;
    rx_idle_pct = 20;
    foreach (hot_rgb[i]) hot_rgb[i] = 24'($urandom);
    repeat (2) begin
      repeat (40) send_pixel(random_pixel(60, 30));
      wait_drained();
    end
  endtask

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_random_stream(400, 0, 0, 50, 20);
    test_random_stream(350, 40, 40, 30, 30);
    test_output_backpressure();
    test_pause_until_drained();
    test_random_stream(650, 15, 15, 40, 25);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: long holds on request, random gaps otherwise
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if ($urandom_range(99) < rx_idle_pct) begin
        result_ready <= 1'b0;
        repeat (pick_gap() - 1) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Inputs only change at rising edges, so the falling edge sees the values
  // that the next rising edge will act on
  always @(negedge clk) begin
    rch_pkg::result_t exp;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, bin %0d count %0d", $time, result.bin, result.count);
        mismatch_count++;
      end else begin
        exp = pending_results.pop_front();
        if (result.bin !== exp.bin) begin
          $display("%0t: bin expected %0d, actual %0d", $time, exp.bin, result.bin);
          mismatch_count++;
        end
        if (result.count !== exp.count) begin
          $display("%0t: count expected %0d, actual %0d", $time, exp.count, result.count);
          mismatch_count++;
        end
        if (result.row_end_out !== exp.row_end_out) begin
          $display("%0t: row_end_out expected %0b, actual %0b", $time, exp.row_end_out,
                   result.row_end_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
